[hw/rtl/simon64_128_block_encrypt_assert.svh]
// Assertion macros for the block encrypt core.
// SIMON_ASSERT_IMPL: overlapping implication, SIMON_ASSERT_NEXT: next-cycle implication.
// Both are clocked by i_clk and disabled while i_rst_n is low.
`ifndef SIMON64_128_BLOCK_ENCRYPT_ASSERT_SVH
`define SIMON64_128_BLOCK_ENCRYPT_ASSERT_SVH

`ifndef SYNTH

`define SIMON_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SIMON_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIMON_ASSERT_IMPL(lbl, ante, cons, msg)

`define SIMON_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/simon_pkg.sv]
`timescale 1ns / 1ps

package simon_pkg;

    localparam int WORD_W      = 32;
    localparam int KEY_W       = 64;
    localparam int ROUNDS      = 44;
    localparam int KEY_WORDS   = 4;
    localparam int CFG_INDEX_W = 1;

    typedef logic [WORD_W-1:0]      t_word;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    // register indexes of the config port
    localparam t_cfg_index CFG_KEY_LOW  = 1'b0;
    localparam t_cfg_index CFG_KEY_HIGH = 1'b1;

    // z3 round constants: 0xfffffffc with bit 0 taken from the sequence
    localparam t_word Z_BASE = 32'hffff_fffc;
    localparam logic [ROUNDS-KEY_WORDS-1:0] Z3_SEQ =
        40'b0001_0010_0000_0111_1010_0110_0011_0101_1101_1011;

    typedef enum logic [1:0] {
        KS_LOAD,
        KS_EXPAND,
        KS_DONE
    } t_ks_state;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_skid_status;

    function automatic t_word rotl(input t_word v, input int n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic t_word rotr(input t_word v, input int n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    // Feistel function of one round
    function automatic t_word round_f(input t_word x);
        round_f = (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
    endfunction

endpackage

[hw/rtl/simon_plain_if.sv]
`timescale 1ns / 1ps

interface simon_plain_if;
    import simon_pkg::*;

    logic  valid;
    logic  ready;
    t_word plain_upper;
    t_word plain_lower;

    modport source (output valid, output plain_upper, output plain_lower, input ready);
    modport sink   (input valid, input plain_upper, input plain_lower, output ready);
endinterface

[hw/rtl/simon_cipher_if.sv]
`timescale 1ns / 1ps

interface simon_cipher_if;
    import simon_pkg::*;

    logic  valid;
    logic  ready;
    t_word cipher_upper;
    t_word cipher_lower;

    modport source (output valid, output cipher_upper, output cipher_lower, input ready);
    modport sink   (input valid, input cipher_upper, input cipher_lower, output ready);
endinterface

[hw/rtl/simon_key_sched.sv]
`timescale 1ns / 1ps

module simon_key_sched #(
    parameter int ROUND_COUNT = simon_pkg::ROUNDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  simon_pkg::t_cfg_index       i_cfg_index,
    input  logic [simon_pkg::KEY_W-1:0] i_cfg_data,
    output simon_pkg::t_word            o_round_key [ROUND_COUNT],
    output logic                        o_ready
);
    import simon_pkg::*;

    localparam int STEPS = ROUND_COUNT - KEY_WORDS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    t_ks_state        r_state;
    t_ks_state        n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_key_low;
    logic [KEY_W-1:0] r_key_high;
    t_word            r_win [KEY_WORDS];
    t_word            r_rk  [ROUND_COUNT];
    t_word            w_tmp;
    t_word            w_new;
    logic             w_load;
    logic             w_step;
    logic             w_last;

    assign w_last = (r_cnt == CNT_W'(STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            KS_LOAD:   n_state = KS_EXPAND;
            KS_EXPAND: n_state = w_last ? KS_DONE : KS_EXPAND;
            KS_DONE:   n_state = KS_DONE;
            default:   n_state = KS_LOAD;
        endcase
        if (i_cfg_we) begin
            n_state = KS_LOAD;
        end
    end

    // state outputs
    always_comb begin
        w_load  = 1'b0;
        w_step  = 1'b0;
        o_ready = 1'b0;
        unique case (r_state)
            KS_LOAD:   w_load  = 1'b1;
            KS_EXPAND: w_step  = 1'b1;
            KS_DONE:   o_ready = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_cnt <= '0;
            end else if (w_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // one schedule word per cycle from a sliding window of four
    always_comb begin
        w_tmp = rotr(r_win[3], 3) ^ r_win[1];
        w_tmp = w_tmp ^ rotr(w_tmp, 1);
        w_new = r_win[0] ^ w_tmp ^ (Z_BASE | t_word'(Z3_SEQ[r_cnt]));
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_win[0] <= r_key_low[WORD_W-1:0];
            r_win[1] <= r_key_low[KEY_W-1:WORD_W];
            r_win[2] <= r_key_high[WORD_W-1:0];
            r_win[3] <= r_key_high[KEY_W-1:WORD_W];
        end else if (w_step) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_win[3];
            r_win[3] <= w_new;
        end
    end

    for (genvar j = 0; j < ROUND_COUNT; j++) begin : g_rk
        if (j < 2) begin : g_key_lo
            always_ff @(posedge i_clk) begin
                if (w_load) begin
                    r_rk[j] <= r_key_low[j*WORD_W +: WORD_W];
                end
            end
        end else if (j < KEY_WORDS) begin : g_key_hi
            always_ff @(posedge i_clk) begin
                if (w_load) begin
                    r_rk[j] <= r_key_high[(j-2)*WORD_W +: WORD_W];
                end
            end
        end else begin : g_exp
            always_ff @(posedge i_clk) begin
                if (w_step && (r_cnt == CNT_W'(j - KEY_WORDS))) begin
                    r_rk[j] <= w_new;
                end
            end
        end
        assign o_round_key[j] = r_rk[j];
    end

endmodule

[hw/rtl/simon_round.sv]
`timescale 1ns / 1ps

module simon_round (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  simon_pkg::t_word i_x,
    input  simon_pkg::t_word i_y,
    input  simon_pkg::t_word i_key,
    output logic             o_valid,
    output simon_pkg::t_word o_x,
    output simon_pkg::t_word o_y
);
    import simon_pkg::*;

    logic  r_valid;
    t_word r_x;
    t_word r_y;
    t_word n_x;

    assign n_x = i_y ^ round_f(i_x) ^ i_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= i_x;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

[hw/rtl/simon_skid.sv]
`timescale 1ns / 1ps

module simon_skid (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  simon_pkg::t_word         i_x,
    input  simon_pkg::t_word         i_y,
    output simon_pkg::t_skid_status  o_status,
    simon_cipher_if.source           o_cipher
);
    import simon_pkg::*;

    logic  r_out_v;
    logic  r_skid_v;
    t_word r_out_x;
    t_word r_out_y;
    t_word r_skid_x;
    t_word r_skid_y;
    logic  w_out_free;

    assign w_out_free = !r_out_v || o_cipher.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_v <= i_valid;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_out_free) begin
                r_out_x <= r_skid_x;
                r_out_y <= r_skid_y;
            end
        end else if (w_out_free) begin
            r_out_x <= i_x;
            r_out_y <= i_y;
        end else begin
            r_skid_x <= i_x;
            r_skid_y <= i_y;
        end
    end

    assign o_cipher.valid        = r_out_v;
    assign o_cipher.cipher_upper = r_out_x;
    assign o_cipher.cipher_lower = r_out_y;
    assign o_status.out_valid    = r_out_v;
    assign o_status.skid_valid   = r_skid_v;

endmodule

[hw/rtl/simon64_128_block_encrypt.sv]
`timescale 1ns / 1ps
// Channel    Dir  Beat payload                    Handshake
// i_plain    in   plain_upper, plain_lower        valid/ready
// o_cipher   out  cipher_upper, cipher_lower      valid/ready
// i_cfg_*    in   index, 64-bit key word          write enable only
//
// One block enters per cycle while i_plain.ready is high; each block passes one round
// per pipeline stage, then the output register.
// After reset and after every key write the schedule unit loads the key words, then
// expands one round key per cycle; i_plain.ready stays low until it is done.
// Reset is synchronous, active low; it clears valid bits and restarts expansion
// from the all-zero key.
// A stalled output fills a one-entry skid register, then the round pipeline freezes
// as a whole; nothing is dropped or repeated.

`include "simon64_128_block_encrypt_assert.svh"

module simon64_128_block_encrypt #(
    parameter int ROUND_COUNT = simon_pkg::ROUNDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    simon_plain_if.sink                 i_plain,
    simon_cipher_if.source              o_cipher,
    input  logic                        i_cfg_we,
    input  simon_pkg::t_cfg_index       i_cfg_index,
    input  logic [simon_pkg::KEY_W-1:0] i_cfg_data
);
    import simon_pkg::*;

    t_word        w_round_key [ROUND_COUNT];
    logic         w_key_ready;
    logic         w_en;
    t_skid_status w_status;

    // stage taps: index 0 is the input beat, index r the state after r rounds
    logic         w_valid [ROUND_COUNT+1];
    t_word        w_x     [ROUND_COUNT+1];
    t_word        w_y     [ROUND_COUNT+1];

    // key registers and the round key store
    simon_key_sched #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_round_key (w_round_key),
        .o_ready     (w_key_ready)
    );

    // whole pipe advances unless the skid register holds a beat
    assign w_en          = !w_status.skid_valid;
    assign i_plain.ready = w_key_ready && w_en;

    assign w_valid[0] = i_plain.valid && w_key_ready;
    assign w_x[0]     = i_plain.plain_upper;
    assign w_y[0]     = i_plain.plain_lower;

    // one Feistel round per stage, each with its own fixed round key
    for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
        simon_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[r]),
            .i_x     (w_x[r]),
            .i_y     (w_y[r]),
            .i_key   (w_round_key[r]),
            .o_valid (w_valid[r+1]),
            .o_x     (w_x[r+1]),
            .o_y     (w_y[r+1])
        );
    end

    // output register plus skid entry
    simon_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[ROUND_COUNT]),
        .i_x      (w_x[ROUND_COUNT]),
        .i_y      (w_y[ROUND_COUNT]),
        .o_status (w_status),
        .o_cipher (o_cipher)
    );

    // no block enters while the schedule is being rebuilt
    `SIMON_ASSERT_IMPL(a_accept_keyed, i_plain.valid && i_plain.ready, w_key_ready, "beat taken during key expansion")

    // skid only fills behind a held output beat
    `SIMON_ASSERT_IMPL(a_skid_behind_out, w_status.skid_valid, o_cipher.valid, "skid full with empty output")

    // skid cannot drain while the output is stalled
    `SIMON_ASSERT_NEXT(a_skid_holds, w_status.skid_valid && !o_cipher.ready, w_status.skid_valid, "skid drained under stall")

endmodule

[bench/simon64_128_block_encrypt_tb.sv]
`timescale 1ns / 1ps

module simon64_128_block_encrypt_tb;
    import simon_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 12;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 142;
    // Round constant bits z3, round 0 first; the key schedule ORs each into 0xfffffffc.
    localparam logic [0:ROUNDS-5] Z3_BITS = 40'b1101101110_1011000110_0101111000_0001001000;
    localparam t_word Z_FLOOR = 32'hffff_fffc;

    // Idle mixes: which side inserts bubbles, and how often.
    typedef enum int {MIX_NONE, MIX_SENDER, MIX_RECEIVER, MIX_BOTH} t_idle_mix;

    typedef struct packed {
        t_word upper;
        t_word lower;
    } t_cipher_beat;

    // Scoreboard: keeps its own key schedule and a queue of ciphertext beats
    // still owed by the block.
    class cipher_scoreboard;
        logic [KEY_W-1:0] key_lo;
        logic [KEY_W-1:0] key_hi;
        t_word            round_key [ROUNDS];
        t_cipher_beat     expected_q [$];
        int unsigned      errors;
        int unsigned      checked;

        function new();
            key_lo  = '0;
            key_hi  = '0;
            errors  = 0;
            checked = 0;
            expand_schedule();
        endfunction

        // m=4 schedule: k[i+4] = k[i] ^ t ^ (t>>>1) ^ z, t = (k[i+3]>>>3) ^ k[i+1]
        function void expand_schedule();
            t_word t;
            round_key[0] = key_lo[31:0];
            round_key[1] = key_lo[63:32];
            round_key[2] = key_hi[31:0];
            round_key[3] = key_hi[63:32];
            for (int i = 0; i < ROUNDS - 4; i++) begin
                t = {round_key[i+3][2:0], round_key[i+3][31:3]} ^ round_key[i+1];
                t = t ^ {t[0], t[31:1]};
                round_key[i+4] = round_key[i] ^ t ^ (Z_FLOOR | t_word'(Z3_BITS[i]));
            end
        endfunction

        function void load_key(t_cfg_index idx, logic [KEY_W-1:0] data);
            if (idx == CFG_KEY_LOW) begin
                key_lo = data;
            end else begin
                key_hi = data;
            end
            expand_schedule();
        endfunction

        // (x<<<1 & x<<<8) ^ x<<<2
        function t_word feistel(t_word x);
            feistel = ({x[30:0], x[31]} & {x[23:0], x[31:24]}) ^ {x[29:0], x[31:30]};
        endfunction

        function void note_plain(t_word upper, t_word lower);
            t_word x;
            t_word y;
            t_word nx;
            x = upper;
            y = lower;
            for (int r = 0; r < ROUNDS; r++) begin
                nx = y ^ feistel(x) ^ round_key[r];
                y  = x;
                x  = nx;
            end
            expected_q.push_back('{x, y});
        endfunction

        function void check_cipher(t_word upper, t_word lower);
            t_cipher_beat want;
            if (expected_q.size() == 0) begin
                $error("unexpected cipher beat %h_%h", upper, lower);
                errors++;
            end else begin
                want = expected_q.pop_front();
                checked++;
                if (upper !== want.upper) begin
                    $error("cipher_upper expected %h actual %h", want.upper, upper);
                    errors++;
                end
                if (lower !== want.lower) begin
                    $error("cipher_lower expected %h actual %h", want.lower, lower);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_index            i_cfg_index;
    logic [KEY_W-1:0]      i_cfg_data;

    simon_plain_if  plain_ch ();
    simon_cipher_if cipher_ch ();

    cipher_scoreboard sb;
    t_idle_mix        idle_mix;
    int unsigned      blocks_sent;
    int unsigned      key_loads;

    simon64_128_block_encrypt dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_plain     (plain_ch),
        .o_cipher    (cipher_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int sender_idle_pct();
        case (idle_mix)
            MIX_SENDER: sender_idle_pct = 85;
            MIX_BOTH:   sender_idle_pct = 6;
            default:    sender_idle_pct = 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mix)
            MIX_RECEIVER: receiver_stall_pct = 85;
            MIX_BOTH:     receiver_stall_pct = 6;
            default:      receiver_stall_pct = 0;
        endcase
    endfunction

    // Mostly uniform words, with all-zero, all-one and one-hot words mixed in.
    function automatic t_word pick_word();
        case ($urandom_range(15))
            0:       pick_word = '0;
            1:       pick_word = '1;
            2:       pick_word = t_word'(1) << $urandom_range(WORD_W - 1);
            default: pick_word = $urandom;
        endcase
    endfunction

    // Sink side: every accepted ciphertext beat is checked, ready is redrawn each cycle.
    // Handshake values are read right after the edge, i.e. before any NBA of that step.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cipher_ch.ready <= 1'b0;
        end else begin
            if (cipher_ch.valid && cipher_ch.ready) begin
                sb.check_cipher(cipher_ch.cipher_upper, cipher_ch.cipher_lower);
            end
            cipher_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // One plaintext beat. Idle bubbles go in ahead of it; valid stays up between
    // back-to-back beats. Ready is low while the key schedule is rebuilt.
    task automatic send_block(input t_word upper, input t_word lower);
        while ($urandom_range(99) < sender_idle_pct()) begin
            plain_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        plain_ch.valid       <= 1'b1;
        plain_ch.plain_upper <= upper;
        plain_ch.plain_lower <= lower;
        do @(posedge i_clk); while (!plain_ch.ready);
        sb.note_plain(upper, lower);
        blocks_sent++;
    endtask

    // Hold the sender off until every owed ciphertext beat has come back.
    // Always waits on the clock before checking, so the valid drop stands alone in its step.
    task automatic drain_pipeline();
        plain_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    // Key write; only issued with the pipeline empty and valid low.
    task automatic write_key(input t_cfg_index idx, input logic [KEY_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.load_key(idx, data);
        key_loads++;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= CFG_KEY_LOW;
        i_cfg_data           <= '0;
        plain_ch.valid       <= 1'b0;
        plain_ch.plain_upper <= '0;
        plain_ch.plain_lower <= '0;
        sb          = new();
        idle_mix    = MIX_NONE;
        blocks_sent = 0;
        key_loads   = 0;

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: schedule built from the reset (all-zero) key, field extremes,
        // one-hot and alternating patterns, sent at full rate.
        send_block('0, '0);
        send_block('1, '1);
        send_block('1, '0);
        send_block('0, '1);
        send_block(32'h8000_0000, 32'h0000_0001);
        send_block(32'h0000_0001, 32'h8000_0000);
        send_block(32'haaaa_aaaa, 32'h5555_5555);

        // All-ones key, both words written back to back.
        drain_pipeline();
        write_key(CFG_KEY_LOW, '1);
        write_key(CFG_KEY_HIGH, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(32'h1234_5678, 32'h9abc_def0);

        // Published Simon 64/128 vector: expect 44c8fc20_b9dfa07a.
        drain_pipeline();
        write_key(CFG_KEY_LOW, 64'h0b0a0908_03020100);
        write_key(CFG_KEY_HIGH, 64'h1b1a1918_13121110);
        send_block(32'h656b_696c, 32'h2064_6e75);

        // Rewrite of one key word alone: the other word must survive.
        drain_pipeline();
        write_key(CFG_KEY_LOW, {$urandom, $urandom});
        send_block(32'h656b_696c, 32'h2064_6e75);
        send_block(pick_word(), pick_word());

        // Random phases, one idle mix each, new key each time. Phases 3 and 7
        // touch only key_low. Every phase also drains once halfway through.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            case (phase)
                0: begin
                    write_key(CFG_KEY_LOW, '0);
                    write_key(CFG_KEY_HIGH, '1);
                end
                1: begin
                    write_key(CFG_KEY_LOW, '1);
                    write_key(CFG_KEY_HIGH, '0);
                end
                3, 7: write_key(CFG_KEY_LOW, {$urandom, $urandom});
                default: begin
                    write_key(CFG_KEY_HIGH, {$urandom, $urandom});
                    write_key(CFG_KEY_LOW, {$urandom, $urandom});
                end
            endcase
            idle_mix = t_idle_mix'(phase % 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    drain_pipeline();
                end
                send_block(pick_word(), pick_word());
            end
        end

        // Wind down: nothing owed, then a pipeline's worth of quiet for strays.
        drain_pipeline();
        repeat (ROUNDS + 10) @(posedge i_clk);

        $display("tb: %0d blocks enciphered, %0d checked, %0d key loads", blocks_sent,
                 sb.checked, key_loads);
        $display("tb: idle mixes none, sender, receiver and both; mismatches %0d", sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
